// ===== rtl/palette_parity_bit_embedder_macros.svh =====
// assertion macros for the palette parity embedder
// expects clk and arst_n in the scope of use
`ifndef PALETTE_PARITY_BIT_EMBEDDER_MACROS_SVH
`define PALETTE_PARITY_BIT_EMBEDDER_MACROS_SVH

`ifndef NO_ASSERTIONS
`define PPBE_ASSERT_IMP(label, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (lhs) |-> (rhs)) \
		else $error("ppbe assertion failed");
`define PPBE_ASSERT_NEXT(label, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (lhs) |=> (rhs)) \
		else $error("ppbe assertion failed");
`else
`define PPBE_ASSERT_IMP(label, lhs, rhs)
`define PPBE_ASSERT_NEXT(label, lhs, rhs)
`endif

`endif

// ===== rtl/ppbe_pkg.sv =====
// shared types, constants and helpers of the palette parity embedder
// no dependencies
package ppbe_pkg;

	localparam int PALETTE_ENTRIES_DEF = 256;
	localparam int IDX_W = 8;
	localparam int COL_W = 8;
	localparam int RGB_W = 3 * COL_W;
	localparam int SQ_W = 2 * COL_W;
	localparam int DIST_W = SQ_W + 2;
	localparam int Q_DEPTH = 2;
	localparam int Q_PW = $clog2(Q_DEPTH);

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_EMBED = 1'b1;

	typedef enum logic [1:0] {
		KD_WRITE,
		KD_EMBED,
		KD_RANGE
	} kind_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_LOOKUP,
		BK_SCAN,
		BK_DRAIN,
		BK_EMIT
	} bk_state_t;

	typedef struct packed {
		kind_t kind;
		logic [IDX_W-1:0] index;
		logic [RGB_W-1:0] colour;
		logic msg_bit;
	} cmd_t;

	typedef struct packed {
		logic vld;
		logic full;
		cmd_t cmd;
	} lnk_t;

	function automatic logic colour_parity(input logic [RGB_W-1:0] c);
		return c[2*COL_W] ^ c[COL_W] ^ c[0];
	endfunction

	function automatic logic [COL_W-1:0] abs_diff(input logic [COL_W-1:0] a,
			input logic [COL_W-1:0] b);
		return (a > b) ? a - b : b - a;
	endfunction

endpackage

// ===== rtl/ppbe_in_if.sv =====
// input channel of the palette parity embedder: palette writes and embeds
// depends on ppbe_pkg
interface ppbe_in_if;
	import ppbe_pkg::*;

	logic valid;
	logic ready;
	logic op;
	logic [IDX_W-1:0] index;
	logic [COL_W-1:0] red;
	logic [COL_W-1:0] green;
	logic [COL_W-1:0] blue;
	logic msg_bit;

	modport source(output valid, op, index, red, green, blue, msg_bit, input ready);
	modport sink(input valid, op, index, red, green, blue, msg_bit, output ready);
endinterface

// ===== rtl/ppbe_out_if.sv =====
// result channel of the palette parity embedder
// depends on ppbe_pkg
interface ppbe_out_if;
	import ppbe_pkg::*;

	logic valid;
	logic ready;
	logic [IDX_W-1:0] pixel_out;
	logic changed;
	logic no_match;

	modport source(output valid, pixel_out, changed, no_match, input ready);
	modport sink(input valid, pixel_out, changed, no_match, output ready);
endinterface

// ===== rtl/ppbe_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
module ppbe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic clk,
	input  logic we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

// ===== rtl/ppbe_front.sv =====
// front end: takes input beats, classifies them and queues them for the back end
// depends on ppbe_pkg and ppbe_in_if
module ppbe_front #(
	parameter int PALETTE_ENTRIES = ppbe_pkg::PALETTE_ENTRIES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	ppbe_in_if.sink item,
	input  logic pop,
	output ppbe_pkg::lnk_t head
);
	import ppbe_pkg::*;

	cmd_t ent_q [Q_DEPTH];
	logic [Q_PW-1:0] wr_ptr_q;
	logic [Q_PW-1:0] rd_ptr_q;
	logic [Q_PW:0] cnt_q;
	cmd_t cls;
	logic in_range;
	logic push;
	logic full;

	assign in_range = {1'b0, item.index} < (IDX_W + 1)'(PALETTE_ENTRIES);
	assign full = cnt_q == (Q_PW + 1)'(Q_DEPTH);
	assign item.ready = !full;
	// out-of-range palette writes are dropped here
	assign push = item.valid && !full && (item.op == OP_EMBED || in_range);

	always_comb begin
		cls.index = item.index;
		cls.colour = {item.red, item.green, item.blue};
		cls.msg_bit = item.msg_bit;
		if (item.op == OP_WRITE) begin
			cls.kind = KD_WRITE;
		end else if (in_range) begin
			cls.kind = KD_EMBED;
		end else begin
			cls.kind = KD_RANGE;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign head.vld = cnt_q != '0;
	assign head.full = full;
	assign head.cmd = ent_q[rd_ptr_q];
endmodule

// ===== rtl/ppbe_back.sv =====
// back end: palette and memo stores, parity check, nearest-entry scan, result register
// depends on ppbe_pkg, ppbe_ram and ppbe_out_if
module ppbe_back #(
	parameter int PALETTE_ENTRIES = ppbe_pkg::PALETTE_ENTRIES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  ppbe_pkg::lnk_t head,
	output logic pop,
	ppbe_out_if.source result
);
	import ppbe_pkg::*;

	localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
	localparam logic [AW-1:0] LAST_A = AW'(PALETTE_ENTRIES - 1);

	bk_state_t state_q, state_d;

	logic [IDX_W-1:0] idx_q;
	logic bit_q;
	logic [RGB_W-1:0] ref_col_q;
	logic ref_par_q;
	logic [AW-1:0] cnt_q;
	logic found_q;
	logic [AW-1:0] best_q;
	logic [DIST_W-1:0] best_d_q;
	logic [PALETTE_ENTRIES-1:0] memo_valid_q;

	logic v_s1;
	logic [AW-1:0] idx_s1;
	logic v_s2;
	logic [AW-1:0] idx_s2;
	logic [SQ_W-1:0] sqr_s2, sqg_s2, sqb_s2;

	logic [IDX_W-1:0] res_pix_q, res_pix_d;
	logic res_chg_q, res_chg_d;
	logic res_nom_q, res_nom_d;

	logic ov_q;
	logic [IDX_W-1:0] opix_q;
	logic ochg_q;
	logic onom_q;

	logic pal_we, memo_we, clr_valid, set_valid, take_cmd, start_scan, issue;
	logic res_ld, out_ld, out_free;
	logic [AW-1:0] pal_raddr;
	logic [RGB_W-1:0] pal_rdata;
	logic [AW:0] memo_rdata;
	logic rd_par, elig;
	logic [COL_W-1:0] dr, dg, db;
	logic [DIST_W-1:0] dist_sum;

	assign pal_raddr = (state_q == BK_SCAN) ? cnt_q : head.cmd.index[AW-1:0];

	ppbe_ram #(.WIDTH(RGB_W), .DEPTH(PALETTE_ENTRIES)) u_pal (
		.clk  (clk),
		.we   (pal_we),
		.waddr(head.cmd.index[AW-1:0]),
		.wdata(head.cmd.colour),
		.raddr(pal_raddr),
		.rdata(pal_rdata)
	);

	// memo entry: none flag above nearest index
	ppbe_ram #(.WIDTH(AW + 1), .DEPTH(PALETTE_ENTRIES)) u_memo (
		.clk  (clk),
		.we   (memo_we),
		.waddr(idx_q[AW-1:0]),
		.wdata({~found_q, best_q}),
		.raddr(head.cmd.index[AW-1:0]),
		.rdata(memo_rdata)
	);

	assign out_free = !ov_q || result.ready;
	assign rd_par = colour_parity(pal_rdata);

	always_comb begin
		state_d = state_q;
		pop = 1'b0;
		pal_we = 1'b0;
		memo_we = 1'b0;
		clr_valid = 1'b0;
		set_valid = 1'b0;
		take_cmd = 1'b0;
		start_scan = 1'b0;
		issue = 1'b0;
		res_ld = 1'b0;
		out_ld = 1'b0;
		res_pix_d = idx_q;
		res_chg_d = 1'b0;
		res_nom_d = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (head.vld) begin
					pop = 1'b1;
					case (head.cmd.kind)
						KD_WRITE: begin
							pal_we = 1'b1;
							clr_valid = 1'b1;
						end
						KD_EMBED: begin
							take_cmd = 1'b1;
							state_d = BK_LOOKUP;
						end
						KD_RANGE: begin
							res_ld = 1'b1;
							res_pix_d = head.cmd.index;
							res_nom_d = 1'b1;
							state_d = BK_EMIT;
						end
						default: ;
					endcase
				end
			end
			BK_LOOKUP: begin
				if (rd_par == bit_q) begin
					res_ld = 1'b1;
					state_d = BK_EMIT;
				end else if (memo_valid_q[idx_q[AW-1:0]]) begin
					res_ld = 1'b1;
					if (memo_rdata[AW]) begin
						res_nom_d = 1'b1;
					end else begin
						res_pix_d = IDX_W'(memo_rdata[AW-1:0]);
						res_chg_d = 1'b1;
					end
					state_d = BK_EMIT;
				end else begin
					start_scan = 1'b1;
					state_d = BK_SCAN;
				end
			end
			BK_SCAN: begin
				issue = 1'b1;
				if (cnt_q == LAST_A) begin
					state_d = BK_DRAIN;
				end
			end
			BK_DRAIN: begin
				if (!v_s1 && !v_s2) begin
					memo_we = 1'b1;
					set_valid = 1'b1;
					res_ld = 1'b1;
					if (found_q) begin
						res_pix_d = IDX_W'(best_q);
						res_chg_d = 1'b1;
					end else begin
						res_nom_d = 1'b1;
					end
					state_d = BK_EMIT;
				end
			end
			BK_EMIT: begin
				if (out_free) begin
					out_ld = 1'b1;
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// scan stage 1: eligibility and squared component differences
	assign elig = v_s1 && (idx_s1 != idx_q[AW-1:0]) && (rd_par != ref_par_q);
	assign dr = abs_diff(pal_rdata[3*COL_W-1:2*COL_W], ref_col_q[3*COL_W-1:2*COL_W]);
	assign dg = abs_diff(pal_rdata[2*COL_W-1:COL_W], ref_col_q[2*COL_W-1:COL_W]);
	assign db = abs_diff(pal_rdata[COL_W-1:0], ref_col_q[COL_W-1:0]);
	// scan stage 2: distance and best-so-far
	assign dist_sum = DIST_W'(sqr_s2) + DIST_W'(sqg_s2) + DIST_W'(sqb_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			ov_q <= 1'b0;
			found_q <= 1'b0;
			memo_valid_q <= '0;
		end else begin
			state_q <= state_d;
			v_s1 <= issue;
			v_s2 <= elig;
			if (out_ld) begin
				ov_q <= 1'b1;
			end else if (result.ready) begin
				ov_q <= 1'b0;
			end
			if (start_scan) begin
				found_q <= 1'b0;
			end else if (v_s2 && (!found_q || dist_sum < best_d_q)) begin
				found_q <= 1'b1;
			end
			if (clr_valid) begin
				memo_valid_q <= '0;
			end else if (set_valid) begin
				memo_valid_q[idx_q[AW-1:0]] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_cmd) begin
			idx_q <= head.cmd.index;
			bit_q <= head.cmd.msg_bit;
		end
		if (start_scan) begin
			ref_col_q <= pal_rdata;
			ref_par_q <= rd_par;
			cnt_q <= '0;
		end else if (issue) begin
			cnt_q <= cnt_q + 1'b1;
		end
		if (!start_scan && v_s2 && (!found_q || dist_sum < best_d_q)) begin
			best_q <= idx_s2;
			best_d_q <= dist_sum;
		end
		idx_s1 <= cnt_q;
		idx_s2 <= idx_s1;
		sqr_s2 <= SQ_W'(dr) * SQ_W'(dr);
		sqg_s2 <= SQ_W'(dg) * SQ_W'(dg);
		sqb_s2 <= SQ_W'(db) * SQ_W'(db);
		if (res_ld) begin
			res_pix_q <= res_pix_d;
			res_chg_q <= res_chg_d;
			res_nom_q <= res_nom_d;
		end
		if (out_ld) begin
			opix_q <= res_pix_q;
			ochg_q <= res_chg_q;
			onom_q <= res_nom_q;
		end
	end

	assign result.valid = ov_q;
	assign result.pixel_out = opix_q;
	assign result.changed = ochg_q;
	assign result.no_match = onom_q;
endmodule

// ===== rtl/palette_parity_bit_embedder.sv =====
// top level of the palette parity embedder: front end, queue link and back end
// depends on ppbe_pkg, ppbe_in_if, ppbe_out_if, ppbe_front, ppbe_back and the macros header
//
// channel  dir  beat
// item     in   op, index, red, green, blue, msg_bit
// result   out  pixel_out, changed, no_match (one per embed, none per palette write)
//
// a palette write is handled in the back end's idle state; an embed whose parity already matches,
// or whose nearest entry is memoised, is settled in the lookup state and goes to the result register
// a memo miss scans every palette entry through the palette's single read port
// a palette write clears the whole memo; reset clears control and memo flags
// a two-beat queue lets input beats be taken while the back end works or the result stalls
`include "palette_parity_bit_embedder_macros.svh"

module palette_parity_bit_embedder #(
	parameter int PALETTE_ENTRIES = ppbe_pkg::PALETTE_ENTRIES_DEF
) (
	input logic clk,
	input logic arst_n,
	ppbe_in_if.sink item,
	ppbe_out_if.source result
);
	import ppbe_pkg::*;

	lnk_t head;
	logic pop;

	ppbe_front #(.PALETTE_ENTRIES(PALETTE_ENTRIES)) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item),
		.pop   (pop),
		.head  (head)
	);

	ppbe_back #(.PALETTE_ENTRIES(PALETTE_ENTRIES)) u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.head  (head),
		.pop   (pop),
		.result(result)
	);

	`PPBE_ASSERT_IMP(a_pop_needs_head, pop, head.vld)
	`PPBE_ASSERT_NEXT(a_embed_holds_back, pop && head.cmd.kind != KD_WRITE, !pop)
	`PPBE_ASSERT_IMP(a_full_stalls_input, head.full, !item.ready)
endmodule

// ===== tb/ppbe_embed_checker.sv =====
// result checker for the palette parity embedder: mirrors the palette and the
// nearest-entry memo from the item channel, predicts every embed and compares
// each result beat in order; depends on ppbe_pkg, ppbe_in_if and ppbe_out_if
module ppbe_embed_checker #(
	parameter int ENTRIES = ppbe_pkg::PALETTE_ENTRIES_DEF
) (
	input logic clk,
	input logic arst_n,
	ppbe_in_if item,
	ppbe_out_if result,
	output int fail_count,
	output int pending,
	output int embeds_seen,
	output int swaps_seen,
	output int misses_seen
);
	import ppbe_pkg::*;

	typedef struct packed {
		logic [IDX_W-1:0] pixel;
		logic changed;
		logic no_match;
	} embed_res_t;

	logic [RGB_W-1:0] hues [256];
	logic [IDX_W-1:0] memo_idx [256];
	logic memo_none [256];
	logic memo_ok [256];
	embed_res_t awaited [$];

	function automatic logic hue_parity(input logic [RGB_W-1:0] c);
		logic [COL_W+1:0] s;
		s = {2'b00, c[RGB_W-1:2*COL_W]} + {2'b00, c[2*COL_W-1:COL_W]} + {2'b00, c[COL_W-1:0]};
		return s[0];
	endfunction

	function automatic logic [SQ_W-1:0] sq_gap(input logic [COL_W-1:0] a,
			input logic [COL_W-1:0] b);
		logic [SQ_W-1:0] d;
		d = (a >= b) ? {{COL_W{1'b0}}, a - b} : {{COL_W{1'b0}}, b - a};
		return d * d;
	endfunction

	function automatic logic [DIST_W-1:0] hue_dist(input logic [RGB_W-1:0] a,
			input logic [RGB_W-1:0] b);
		return {2'b00, sq_gap(a[RGB_W-1:2*COL_W], b[RGB_W-1:2*COL_W])}
			+ {2'b00, sq_gap(a[2*COL_W-1:COL_W], b[2*COL_W-1:COL_W])}
			+ {2'b00, sq_gap(a[COL_W-1:0], b[COL_W-1:0])};
	endfunction

	function automatic void scan_nearest(input logic [IDX_W-1:0] p);
		logic own;
		logic found;
		logic [IDX_W-1:0] best;
		logic [DIST_W-1:0] best_d;
		logic [DIST_W-1:0] d;
		int i;
		own = hue_parity(hues[p]);
		found = 1'b0;
		best = '0;
		best_d = '0;
		for (i = 0; i < ENTRIES; i++) begin
			if (i != int'(p) && hue_parity(hues[i]) != own) begin
				d = hue_dist(hues[p], hues[i]);
				if (!found || d < best_d) begin
					found = 1'b1;
					best = IDX_W'(i);
					best_d = d;
				end
			end
		end
		memo_idx[p] = best;
		memo_none[p] = !found;
		memo_ok[p] = 1'b1;
	endfunction

	function automatic embed_res_t predict_embed(input logic [IDX_W-1:0] idx, input logic msg);
		embed_res_t r;
		r.pixel = idx;
		r.changed = 1'b0;
		r.no_match = 1'b0;
		if (int'(idx) >= ENTRIES) begin
			r.no_match = 1'b1;
		end else if (hue_parity(hues[idx]) != msg) begin
			if (!memo_ok[idx])
				scan_nearest(idx);
			if (memo_none[idx]) begin
				r.no_match = 1'b1;
			end else begin
				r.pixel = memo_idx[idx];
				r.changed = 1'b1;
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		int k;
		embed_res_t want;
		if (!arst_n) begin
			for (k = 0; k < 256; k++)
				memo_ok[k] = 1'b0;
			awaited.delete();
			fail_count = 0;
			pending = 0;
			embeds_seen = 0;
			swaps_seen = 0;
			misses_seen = 0;
		end else begin
			if (item.valid && item.ready) begin
				if (item.op == OP_WRITE) begin
					if (int'(item.index) < ENTRIES) begin
						hues[item.index] = {item.red, item.green, item.blue};
						for (k = 0; k < 256; k++)
							memo_ok[k] = 1'b0;
					end
				end else begin
					awaited.push_back(predict_embed(item.index, item.msg_bit));
				end
			end
			if (result.valid && result.ready) begin
				if (awaited.size() == 0) begin
					$error("result beat with no embed pending: pixel_out %0d", result.pixel_out);
					fail_count++;
				end else begin
					want = awaited.pop_front();
					embeds_seen++;
					if (want.changed)
						swaps_seen++;
					if (want.no_match)
						misses_seen++;
					if (result.pixel_out !== want.pixel) begin
						$error("pixel_out: expected %0d, got %0d", want.pixel, result.pixel_out);
						fail_count++;
					end
					if (result.changed !== want.changed) begin
						$error("changed: expected %0d, got %0d", want.changed, result.changed);
						fail_count++;
					end
					if (result.no_match !== want.no_match) begin
						$error("no_match: expected %0d, got %0d", want.no_match,
							result.no_match);
						fail_count++;
					end
				end
			end
			pending = awaited.size();
		end
	end

endmodule

// ===== tb/tb.sv =====
// testbench top for the palette parity embedder: clock, reset, item stimulus,
// result back-pressure and the verdict; depends on ppbe_pkg, both channel
// interfaces, the block and ppbe_embed_checker
module tb;
	import ppbe_pkg::*;

	typedef enum logic [1:0] {
		FILL_RANDOM,
		FILL_EVEN,
		FILL_ODD,
		FILL_FEW
	} fill_mode_t;

	localparam int RANDOM_ITEMS = 120;
	localparam int HOLD_CYCLES = 600;
	localparam int SETTLE_CYCLES = 400;

	logic clk;
	logic arst_n;
	int fail_count;
	int pending;
	int embeds_seen;
	int swaps_seen;
	int misses_seen;
	int writes_sent;
	bit hold_req;
	bit hold_done;

	ppbe_in_if item_ch();
	ppbe_out_if result_ch();

	palette_parity_bit_embedder u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(result_ch)
	);

	ppbe_embed_checker u_chk (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(result_ch),
		.fail_count(fail_count),
		.pending(pending),
		.embeds_seen(embeds_seen),
		.swaps_seen(swaps_seen),
		.misses_seen(misses_seen)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 4);
		return $urandom_range(10, 60);
	endfunction

	function automatic logic [COL_W-1:0] pick_level();
		int r;
		r = $urandom_range(0, 99);
		if (r < 15)
			return '0;
		else if (r < 30)
			return '1;
		return COL_W'($urandom);
	endfunction

	function automatic logic [RGB_W-1:0] make_hue(input fill_mode_t mode);
		logic [RGB_W-1:0] few [6];
		logic [COL_W-1:0] r;
		logic [COL_W-1:0] g;
		logic [COL_W-1:0] b;
		few = '{24'h000000, 24'hFFFFFF, 24'h000001, 24'h010000, 24'h808081, 24'h0A141E};
		if (mode == FILL_FEW)
			return few[$urandom_range(0, 5)];
		r = pick_level();
		g = pick_level();
		b = pick_level();
		if (mode == FILL_EVEN && (r[0] ^ g[0] ^ b[0]))
			b[0] = ~b[0];
		if (mode == FILL_ODD && !(r[0] ^ g[0] ^ b[0]))
			b[0] = ~b[0];
		return {r, g, b};
	endfunction

	task automatic send_beat(input logic op, input logic [IDX_W-1:0] idx,
			input logic [RGB_W-1:0] hue, input logic msg);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.op <= op;
		item_ch.index <= idx;
		item_ch.red <= hue[RGB_W-1:2*COL_W];
		item_ch.green <= hue[2*COL_W-1:COL_W];
		item_ch.blue <= hue[COL_W-1:0];
		item_ch.msg_bit <= msg;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		if (op == OP_WRITE)
			writes_sent++;
	endtask

	task automatic write_entry(input logic [IDX_W-1:0] idx, input logic [RGB_W-1:0] hue);
		send_beat(OP_WRITE, idx, hue, 1'($urandom));
	endtask

	task automatic embed_pixel(input logic [IDX_W-1:0] idx, input logic msg);
		send_beat(OP_EMBED, idx, RGB_W'($urandom), msg);
	endtask

	task automatic fill_palette(input fill_mode_t mode);
		int i;
		for (i = 0; i < PALETTE_ENTRIES_DEF; i++)
			write_entry(IDX_W'(i), make_hue(mode));
	endtask

	task automatic random_items(input int n, input fill_mode_t mode);
		logic [IDX_W-1:0] hot [8];
		logic [IDX_W-1:0] idx;
		int i;
		for (i = 0; i < 8; i++)
			hot[i] = IDX_W'($urandom);
		for (i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < 7) begin
				write_entry(IDX_W'($urandom), make_hue(mode));
			end else begin
				idx = $urandom_range(0, 1) ? hot[$urandom_range(0, 7)] : IDX_W'($urandom);
				embed_pixel(idx, 1'($urandom));
			end
		end
	endtask

	// result side back-pressure, with one long hold-off once asked for
	initial begin
		int gap;
		result_ch.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (hold_req && !hold_done) begin
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end else begin
				result_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 40)) @(posedge clk);
				gap = pick_gap();
				if (gap > 0) begin
					result_ch.ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
	end

	initial begin
		#20000000;
		$display("palette_parity_bit_embedder verification failed");
		$finish;
	end

	initial begin
		writes_sent = 0;
		hold_req = 1'b0;
		hold_done = 1'b0;
		arst_n <= 1'b0;
		item_ch.valid <= 1'b0;
		item_ch.op <= OP_WRITE;
		item_ch.index <= '0;
		item_ch.red <= '0;
		item_ch.green <= '0;
		item_ch.blue <= '0;
		item_ch.msg_bit <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single-parity palette: no opposite entry, memoised miss
		fill_palette(FILL_EVEN);
		embed_pixel(8'd40, 1'b1);
		embed_pixel(8'd40, 1'b1);
		embed_pixel(8'd41, 1'b0);
		write_entry(8'd77, make_hue(FILL_ODD));
		embed_pixel(8'd12, 1'b1);

		// extremes, distance ties, memo hits and memo clearing
		write_entry(8'd0, 24'h000000);
		write_entry(8'd255, 24'hFFFFFF);
		write_entry(8'd1, 24'h000001);
		write_entry(8'd2, 24'h000100);
		write_entry(8'd3, 24'h010000);
		embed_pixel(8'd0, 1'b0);
		embed_pixel(8'd0, 1'b1);
		embed_pixel(8'd0, 1'b1);
		embed_pixel(8'd255, 1'b1);
		embed_pixel(8'd255, 1'b0);
		embed_pixel(8'd255, 1'b0);
		embed_pixel(8'd1, 1'b0);
		embed_pixel(8'd2, 1'b1);
		write_entry(8'd1, 24'h000000);
		embed_pixel(8'd0, 1'b1);
		embed_pixel(8'd1, 1'b1);

		hold_req = 1'b1;
		random_items(RANDOM_ITEMS / 2, FILL_RANDOM);
		random_items(RANDOM_ITEMS / 2, FILL_FEW);
		item_ch.valid <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("covered %0d palette writes and %0d embeds", writes_sent, embeds_seen);
		$display("%0d pixels swapped, %0d without an opposite-parity entry",
			swaps_seen, misses_seen);
		if (fail_count == 0 && pending == 0)
			$display("palette_parity_bit_embedder verification clean");
		else
			$display("palette_parity_bit_embedder verification failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/ppbe_pkg.sv
rtl/ppbe_in_if.sv
rtl/ppbe_out_if.sv
rtl/ppbe_ram.sv
rtl/ppbe_front.sv
rtl/ppbe_back.sv
rtl/palette_parity_bit_embedder.sv
tb/ppbe_embed_checker.sv
tb/tb.sv
